// ===== sv/pva_pkg.sv =====
// Shared types and constants of the primitive vertex assembler.
package pva_pkg;

	// Command opcodes
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_LINE = 2'd1;
	localparam logic [1:0] OP_TRI  = 2'd2;

	// Q16.16 one
	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [9:0]         index_a;
		logic [9:0]         index_b;
		logic [9:0]         index_c;
		logic signed [31:0] clip_x;
		logic signed [31:0] clip_y;
		logic signed [31:0] clip_z;
		logic signed [31:0] clip_w;
	} cmd_t;

	typedef struct packed {
		logic [9:0]         vertex_index;
		logic signed [31:0] win_x;
		logic signed [31:0] win_y;
		logic signed [31:0] win_z;
		logic signed [31:0] win_w;
		logic               accepted;
		logic               last;
	} result_t;

	// One stored position (clip or window), x first
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
	} pos_t;

	// Status one axis lane reports to the merge stage
	typedef struct packed {
		logic done;
		logic in_range;
	} lane_stat_t;

endpackage

// ===== sv/primitive_vertex_assembler_unit.sv =====
// Top level: vertex store, done marks, window cache, sequencer and config port.
//
// Commands enter on cmd when start is high and busy is low. A load (opcode 0)
// gives no result. A line or triangle first reads each vertex and tests it;
// a failing vertex ends the primitive with one rejection result. Otherwise
// each vertex gives one result on result, marked by result_valid for one
// cycle: a cached vertex comes from the window cache, a fresh one from the
// 48-step divider that the three axis lanes run side by side (skipped when w
// is zero). Each result beat shows up the cycle after its vertex finishes.
// The receiver cannot stall; results come as soon as they are ready. One
// command is worked on at a time. After reset the block clears the done
// marks, one slot per cycle, and holds busy high meanwhile. The user must
// write the viewport registers over the APB port only while the block is
// idle; the block does not enforce this. They reset to 640 by 480.
module primitive_vertex_assembler_unit import pva_pkg::*; #(
	parameter int VERTEX_SLOTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        result_valid,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SW    = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
	localparam int RECIP = (1 << 20) / VERTEX_SLOTS;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_CRD  = 3'd2;
	localparam logic [2:0] S_CHK  = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;
	localparam logic [2:0] S_EVAL = 3'd5;
	localparam logic [2:0] S_WAIT = 3'd6;

	localparam logic REG_WIDTH = 1'b0;

	// slot = index mod VERTEX_SLOTS by reciprocal and one correction
	function automatic logic [SW-1:0] slot_of(input logic [9:0] idx);
		logic [26:0] prod;
		logic [26:0] r;
		prod = 27'(idx) * 27'(RECIP);
		r = 27'(idx) - 27'(prod[26:20]) * 27'(VERTEX_SLOTS);
		if (r >= 27'(VERTEX_SLOTS)) r = r - 27'(VERTEX_SLOTS);
		return r[SW-1:0];
	endfunction

	logic [2:0]    st_q;
	logic [SW-1:0] clr_q;
	logic [1:0]    op_q;
	logic [9:0]    ia_q, ib_q, ic_q;
	logic [1:0]    k_q;
	logic [14:0]   vw_q, vh_q;
	result_t       out_q;
	logic          strobe_q;

	pos_t vert_mem [VERTEX_SLOTS];
	logic mark_mem [VERTEX_SLOTS];
	pos_t cache_mem [VERTEX_SLOTS];

	pos_t          vrd_q, crd_q;
	logic          mrd_q;

	logic          accept;
	logic [9:0]    idx_sel;
	logic [SW-1:0] rd_slot, ld_slot;
	logic [1:0]    last_k;
	logic          load_we, mark_we, mark_wd, cache_we;
	logic [SW-1:0] mark_wa;
	logic          go;
	lane_stat_t    st_x, st_y, st_z;
	logic signed [31:0] rx, ry, rz;
	logic          rejected, all_done;
	pos_t          win;
	logic          cfg_we;

	assign busy    = (st_q != S_IDLE);
	assign accept  = start && !busy;
	assign idx_sel = (k_q == 2'd0) ? ia_q : ((k_q == 2'd1) ? ib_q : ic_q);
	assign rd_slot = slot_of(idx_sel);
	assign ld_slot = slot_of(cmd.index_a);
	assign last_k  = (op_q == OP_TRI) ? 2'd2 : 2'd1;
	assign load_we = accept && (cmd.opcode == OP_LOAD);
	assign go      = (st_q == S_EVAL) && !mrd_q;
	assign cache_we = (st_q == S_WAIT) && all_done;

	// done-mark write port: clearing pass, load, fresh result
	always_comb begin
		mark_we = 1'b0;
		mark_wa = rd_slot;
		mark_wd = 1'b0;
		if (st_q == S_CLR) begin
			mark_we = 1'b1;
			mark_wa = clr_q;
		end else if (load_we) begin
			mark_we = 1'b1;
			mark_wa = ld_slot;
		end else if (cache_we) begin
			mark_we = 1'b1;
			mark_wd = 1'b1;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (load_we) vert_mem[ld_slot] <= {cmd.clip_x, cmd.clip_y, cmd.clip_z, cmd.clip_w};
		vrd_q <= vert_mem[rd_slot];
	end

	always_ff @(posedge clk) begin
		if (mark_we) mark_mem[mark_wa] <= mark_wd;
		mrd_q <= mark_mem[rd_slot];
	end

	always_ff @(posedge clk) begin
		if (cache_we) cache_mem[rd_slot] <= win;
		crd_q <= cache_mem[rd_slot];
	end

	// axis lanes
	pva_axis_lane u_lane_x (
		.clk(clk), .arst_n(arst_n), .go(go), .flip(1'b0), .scale({1'b0, vw_q}),
		.v(vrd_q.x), .w(vrd_q.w), .stat(st_x), .res(rx)
	);
	pva_axis_lane u_lane_y (
		.clk(clk), .arst_n(arst_n), .go(go), .flip(1'b1), .scale({1'b0, vh_q}),
		.v(vrd_q.y), .w(vrd_q.w), .stat(st_y), .res(ry)
	);
	pva_axis_lane u_lane_z (
		.clk(clk), .arst_n(arst_n), .go(go), .flip(1'b0), .scale(16'd1),
		.v(vrd_q.z), .w(vrd_q.w), .stat(st_z), .res(rz)
	);

	pva_merge u_merge (
		.stat_x(st_x), .stat_y(st_y), .stat_z(st_z),
		.res_x(rx), .res_y(ry), .res_z(rz),
		.w_zero(vrd_q.w == 32'sd0),
		.rejected(rejected), .all_done(all_done), .win(win)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_CLR;
			clr_q    <= '0;
			k_q      <= 2'd0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(VERTEX_SLOTS - 1)) st_q <= S_IDLE;
				end
				S_IDLE: begin
					k_q <= 2'd0;
					if (accept && (cmd.opcode == OP_LINE || cmd.opcode == OP_TRI)) begin
						st_q <= S_CRD;
					end
				end
				S_CRD: st_q <= S_CHK;
				S_CHK: begin
					if (rejected) begin
						strobe_q <= 1'b1;
						st_q     <= S_IDLE;
					end else if (k_q == last_k) begin
						k_q  <= 2'd0;
						st_q <= S_RD;
					end else begin
						k_q  <= k_q + 2'd1;
						st_q <= S_CRD;
					end
				end
				S_RD: st_q <= S_EVAL;
				S_EVAL, S_WAIT: begin
					if ((st_q == S_EVAL && mrd_q) || (st_q == S_WAIT && all_done)) begin
						strobe_q <= 1'b1;
						if (k_q == last_k) st_q <= S_IDLE;
						else begin
							k_q  <= k_q + 2'd1;
							st_q <= S_RD;
						end
					end else begin
						st_q <= S_WAIT;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// command and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= cmd.opcode;
			ia_q <= cmd.index_a;
			ib_q <= cmd.index_b;
			ic_q <= cmd.index_c;
		end
		if (st_q == S_CHK && rejected) begin
			out_q.vertex_index <= ia_q;
			out_q.win_x        <= 32'sd0;
			out_q.win_y        <= 32'sd0;
			out_q.win_z        <= 32'sd0;
			out_q.win_w        <= 32'sd0;
			out_q.accepted     <= 1'b0;
			out_q.last         <= 1'b1;
		end else if (st_q == S_EVAL || st_q == S_WAIT) begin
			out_q.vertex_index <= idx_sel;
			out_q.win_x        <= (st_q == S_EVAL) ? crd_q.x : win.x;
			out_q.win_y        <= (st_q == S_EVAL) ? crd_q.y : win.y;
			out_q.win_z        <= (st_q == S_EVAL) ? crd_q.z : win.z;
			out_q.win_w        <= (st_q == S_EVAL) ? crd_q.w : win.w;
			out_q.accepted     <= 1'b1;
			out_q.last         <= (k_q == last_k);
		end
	end

	assign result_valid = strobe_q;
	assign result       = out_q;

	// configuration port
	assign cfg_we = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_WIDTH) ? {17'd0, vw_q} : {17'd0, vh_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vw_q <= 15'd640;
			vh_q <= 15'd480;
		end else if (cfg_we) begin
			if (paddr[2] == REG_WIDTH) vw_q <= pwdata[14:0];
			else vh_q <= pwdata[14:0];
		end
	end

endmodule

// ===== sv/pva_axis_lane.sv =====
// One axis lane: clip test, iterative Q16.16 divide by w, viewport scale.
module pva_axis_lane import pva_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic               flip,
	input  logic [15:0]        scale,
	input  logic signed [31:0] v,
	input  logic signed [31:0] w,
	output lane_stat_t         stat,
	output logic signed [31:0] res
);

	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_DIV  = 3'd1;
	localparam logic [2:0] L_SAT  = 3'd2;
	localparam logic [2:0] L_MUL  = 3'd3;
	localparam logic [2:0] L_FIN  = 3'd4;

	logic [2:0]         st_q;
	logic [5:0]         cnt_q;
	logic [47:0]        dvd_q;
	logic [31:0]        rem_q;
	logic [31:0]        dvs_q;
	logic               neg_q;
	logic               flip_q;
	logic [15:0]        scale_q;
	logic signed [31:0] quo_q;
	logic signed [50:0] prod_q;
	logic signed [31:0] res_q;
	logic               done_q;

	logic signed [32:0] v33, w33;
	logic [31:0]        v_mag, w_mag;
	logic [32:0]        trial, diff;
	logic               ge;
	logic [47:0]        neg_mag;
	logic signed [33:0] t34;
	logic signed [16:0] s17;
	logic signed [50:0] hsum, half;

	// clip test on the current operands
	assign v33 = 33'(v);
	assign w33 = 33'(w);
	assign stat.in_range = (v33 >= -w33) && (v33 <= w33);
	assign stat.done     = done_q;
	assign res           = res_q;

	assign v_mag = v[31] ? 32'(-v33) : v;
	assign w_mag = w[31] ? 32'(-w33) : w;

	// one restoring step
	assign trial = {rem_q, dvd_q[47]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	assign neg_mag = 48'd0 - dvd_q;

	// viewport operand: q+1 or 1-q
	assign t34  = flip_q ? (34'(ONE_Q16) - 34'(quo_q)) : (34'(quo_q) + 34'(ONE_Q16));
	assign s17  = signed'({1'b0, scale_q});
	assign hsum = prod_q + 51'(prod_q[50]);
	assign half = hsum >>> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				L_IDLE: begin
					if (go) begin
						if (w == 32'sd0) st_q <= L_MUL;
						else st_q <= L_DIV;
					end
				end
				L_DIV: begin
					if (cnt_q == 6'd0) st_q <= L_SAT;
				end
				L_SAT: st_q <= L_MUL;
				L_MUL: st_q <= L_FIN;
				L_FIN: begin
					st_q   <= L_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE: begin
				if (go) begin
					dvd_q   <= {v_mag, 16'd0};
					dvs_q   <= w_mag;
					rem_q   <= 32'd0;
					neg_q   <= v[31] ^ w[31];
					cnt_q   <= 6'd47;
					quo_q   <= v;
					flip_q  <= flip;
					scale_q <= scale;
				end
			end
			L_DIV: begin
				rem_q <= ge ? diff[31:0] : trial[31:0];
				dvd_q <= {dvd_q[46:0], ge};
				cnt_q <= cnt_q - 6'd1;
			end
			L_SAT: begin
				if (neg_q) begin
					if (dvd_q > 48'h0000_8000_0000) quo_q <= 32'sh8000_0000;
					else quo_q <= signed'(neg_mag[31:0]);
				end else begin
					if (dvd_q > 48'h0000_7FFF_FFFF) quo_q <= 32'sh7FFF_FFFF;
					else quo_q <= signed'(dvd_q[31:0]);
				end
			end
			L_MUL: prod_q <= t34 * s17;
			L_FIN: begin
				if (half > 51'sh0_0000_7FFF_FFFF) res_q <= 32'sh7FFF_FFFF;
				else if (half < -51'sh0_0000_8000_0000) res_q <= 32'sh8000_0000;
				else res_q <= half[31:0];
			end
			default: ;
		endcase
	end

endmodule

// ===== sv/pva_merge.sv =====
// Merges the three axis lanes: rejection decision and window position.
module pva_merge import pva_pkg::*; (
	input  lane_stat_t         stat_x,
	input  lane_stat_t         stat_y,
	input  lane_stat_t         stat_z,
	input  logic signed [31:0] res_x,
	input  logic signed [31:0] res_y,
	input  logic signed [31:0] res_z,
	input  logic               w_zero,
	output logic               rejected,
	output logic               all_done,
	output pos_t               win
);

	// a vertex fails only when every axis is outside
	assign rejected = !(stat_x.in_range || stat_y.in_range || stat_z.in_range);
	assign all_done = stat_x.done && stat_y.done && stat_z.done;

	always_comb begin
		win.x = res_x;
		win.y = res_y;
		win.z = res_z;
		win.w = w_zero ? 32'sd0 : ONE_Q16;
	end

endmodule
